// ===== rtl/core/pc1_pkg.sv =====
// Shared constants, codes and the controller-to-datapath command for the
// PC1 stream cipher core. No dependencies.
package pc1_pkg;

  localparam int KEY_BYTES  = 16;
  localparam int ROUNDS     = 8;
  localparam int ROUND_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [15:0] MUL_A = 16'h4e35;
  localparam logic [15:0] MUL_B = 16'h015a;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd2;

  // round phases: one multiply on the shared unit in each
  localparam logic [1:0] PH_KA = 2'd0;  // key word times MUL_A
  localparam logic [1:0] PH_KB = 2'd1;  // key word times MUL_B
  localparam logic [1:0] PH_TA = 2'd2;  // accumulator plus round times MUL_A

  typedef struct packed {
    logic               load;     // item taken this cycle
    logic               mul_en;   // shared multiplier busy
    logic [1:0]         phase;
    logic [ROUND_W-1:0] round;
    logic               close;    // fold the previous round into the carried words
    logic               finish;   // last fold, write result and running key
  } pc1_cmd_t;

endpackage

// ===== rtl/core/pc1_in_if.sv =====
// Input channel of the PC1 core: valid/ready plus one data byte and the
// buffer start flag. No dependencies.
interface pc1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_buffer;

  modport source (output valid, output data_byte, output start_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input start_of_buffer, output ready);
endinterface

// ===== rtl/core/pc1_out_if.sv =====
// Output channel of the PC1 core: valid/ready plus the transformed byte.
// No dependencies.
interface pc1_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink   (input valid, input result_byte, output ready);
endinterface

// ===== rtl/core/pc1_ctrl.sv =====
// Sequencer for the PC1 core: walks eight rounds of three multiply phases
// and owns the handshake state. Depends on pc1_pkg.
module pc1_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output pc1_pkg::pc1_cmd_t cmd
);
  import pc1_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RUN    = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [1:0]         phase;
  logic [1:0]         phase_next;
  logic [ROUND_W-1:0] round;
  logic [ROUND_W-1:0] round_next;
  logic               out_valid_next;
  logic               accept;
  logic               finish;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // hold the last fold while the previous result is still waiting
  assign finish   = (state == S_FINISH) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    phase_next = phase;
    round_next = round;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RUN;
          phase_next = PH_KA;
          round_next = '0;
        end
      end
      S_RUN: begin
        if (phase == PH_TA) begin
          phase_next = PH_KA;
          if (round == ROUND_W'(ROUNDS - 1)) begin
            state_next = S_FINISH;
          end else begin
            round_next = round + 1'b1;
          end
        end else begin
          phase_next = phase + 1'b1;
        end
      end
      S_FINISH: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_KA;
      round     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      round     <= round_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cmd.load   = accept;
    cmd.mul_en = (state == S_RUN);
    cmd.phase  = phase;
    cmd.round  = round;
    cmd.close  = ((state == S_RUN) && (phase == PH_KA) && (round != '0)) || finish;
    cmd.finish = finish;
  end

endmodule

// ===== rtl/core/pc1_dpath.sv =====
// Datapath of the PC1 core: configuration registers, running key, carried
// words and one shared 16x16 multiplier. Depends on pc1_pkg.
module pc1_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         write_enable,
  input  logic [pc1_pkg::CFG_IDX_W-1:0]  reg_index,
  input  logic [pc1_pkg::CFG_DATA_W-1:0] write_data,
  input  pc1_pkg::pc1_cmd_t            cmd,
  input  logic [7:0]                   data_byte,
  input  logic                         start_of_buffer,
  output logic [7:0]                   result_byte
);
  import pc1_pkg::*;

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        direction;

  logic [7:0]  running_key [KEY_BYTES];
  logic [15:0] carry_word;
  logic [15:0] accum_word;
  logic [15:0] key_word;
  logic [15:0] new_word;
  logic [15:0] new_carry;
  logic [15:0] product;
  logic [15:0] out_acc;
  logic [7:0]  data_reg;

  logic [15:0] op_x;
  logic [15:0] op_y;
  logic [31:0] product_full;
  logic [15:0] t_word;
  logic [ROUND_W-1:0] pair_idx;
  logic [15:0] pair;
  logic [15:0] acc_new;
  logic [15:0] round_out;
  logic [15:0] mix;
  logic [7:0]  mask;
  logic [7:0]  res;
  logic [7:0]  plain;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high  <= '0;
      key_low   <= '0;
      direction <= 1'b0;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_KEY_HIGH:  key_high  <= write_data;
        REG_KEY_LOW:   key_low   <= write_data;
        REG_DIRECTION: direction <= write_data[0];
        default: ;
      endcase
    end
  end

  assign t_word   = accum_word + 16'(cmd.round);
  assign pair_idx = cmd.round + 1'b1;
  assign pair     = {running_key[{pair_idx, 1'b0}], running_key[{pair_idx, 1'b1}]};

  always_comb begin
    case (cmd.phase)
      PH_KA: begin
        op_x = key_word;
        op_y = MUL_A;
      end
      PH_KB: begin
        op_x = key_word;
        op_y = MUL_B;
      end
      PH_TA: begin
        op_x = t_word;
        op_y = MUL_A;
      end
      default: begin
        op_x = key_word;
        op_y = MUL_A;
      end
    endcase
  end

  assign product_full = 32'(op_x) * 32'(op_y);

  // fold: product holds (accum + round) * MUL_A of the round just done
  assign acc_new   = carry_word + product + new_carry;
  assign round_out = new_word ^ acc_new;
  assign mix       = out_acc ^ round_out;
  assign mask      = mix[15:8] ^ mix[7:0];
  assign res       = data_reg ^ mask;
  assign plain     = direction ? data_reg : res;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      product <= product_full[15:0];
      unique case (cmd.phase)
        PH_KB:   new_word <= product + 16'd1;
        PH_TA: begin
          new_carry <= product;
          key_word  <= new_word ^ pair;
        end
        default: ;
      endcase
    end
    if (cmd.load) begin
      data_reg <= data_byte;
      out_acc  <= '0;
      key_word <= start_of_buffer ? key_high[63:48] : {running_key[0], running_key[1]};
    end else if (cmd.close) begin
      out_acc <= mix;
    end
    if (cmd.finish) begin
      result_byte <= res;
    end
  end

  // carried words and running key have defined reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_word <= '0;
      accum_word <= '0;
      for (int j = 0; j < KEY_BYTES; j++) begin
        running_key[j] <= '0;
      end
    end else if (cmd.load) begin
      if (start_of_buffer) begin
        carry_word <= '0;
        accum_word <= '0;
        for (int j = 0; j < KEY_BYTES / 2; j++) begin
          running_key[j]                 <= key_high[8 * (KEY_BYTES / 2 - 1 - j) +: 8];
          running_key[j + KEY_BYTES / 2] <= key_low[8 * (KEY_BYTES / 2 - 1 - j) +: 8];
        end
      end
    end else begin
      if (cmd.close) begin
        carry_word <= new_carry;
        accum_word <= acc_new;
      end
      if (cmd.finish) begin
        for (int j = 0; j < KEY_BYTES; j++) begin
          running_key[j] <= running_key[j] ^ plain;
        end
      end
    end
  end

endmodule

// ===== rtl/core/pc1_stream_cipher_core.sv =====
// Top level of the PC1 stream cipher: joins the sequencer and the datapath
// to the two item channels and the config port. Depends on pc1_pkg,
// pc1_in_if, pc1_out_if, pc1_ctrl and pc1_dpath.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    data_byte[7:0], start_of_buffer
//   out_chan  out  valid/ready    result_byte[7:0]
//   config    in   write_enable   reg_index[1:0], write_data[63:0]
//
// One item at a time: from acceptance to the result register, eight
// rounds of three phases on the single 16x16 multiplier plus a final
// fold. The next item is taken the cycle after the result is written, even
// if that result is still waiting on out_chan. A stalled output holds the
// final fold only. Reset (rst, synchronous) clears key, carried words and
// running key to zero.
module pc1_stream_cipher_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [pc1_pkg::CFG_IDX_W-1:0]  reg_index,
  input  logic [pc1_pkg::CFG_DATA_W-1:0] write_data,
  pc1_in_if.sink                        in_chan,
  pc1_out_if.source                     out_chan
);
  import pc1_pkg::*;

  pc1_cmd_t cmd;

  pc1_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  pc1_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .write_enable    (write_enable),
    .reg_index       (reg_index),
    .write_data      (write_data),
    .cmd             (cmd),
    .data_byte       (in_chan.data_byte),
    .start_of_buffer (in_chan.start_of_buffer),
    .result_byte     (out_chan.result_byte)
  );

endmodule

// ===== rtl/core/pc1_checker.sv =====
// Port-level checks for the PC1 core, bound onto pc1_stream_cipher_core.
// Depends on the top level's ports only.
module pc1_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] result_byte
);

  // busy straight after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an item was taken");

  // rounds cannot be skipped: still busy at the last round
  a_busy_through_rounds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##24 !in_ready)
    else $error("input ready before all rounds ran");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(result_byte))
    else $error("result changed while stalled");

endmodule

bind pc1_stream_cipher_core pc1_checker u_pc1_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .result_byte (out_chan.result_byte)
);
